>>> sv/zrht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrht_pkg
// Types and codes shared by the z-ordered rectangle hit table.
// ----------------------------------------------------------------------------
package zrht_pkg;

	typedef enum logic [2:0] {
		MODE_UPSERT   = 3'd0,
		MODE_REMOVE   = 3'd1,
		MODE_SET_VIS  = 3'd2,
		MODE_SET_GEOM = 3'd3,
		MODE_RAISE    = 3'd4,
		MODE_CONTAINS = 3'd5,
		MODE_BOUNDS   = 3'd6,
		MODE_ROUTE    = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_TAKE,
		S_REN,
		S_REN_CHK,
		S_GIVE,
		S_UNION,
		S_UEND,
		S_ROUTE,
		S_RFIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [31:0]        surface_id;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
		logic               make_visible;
		logic [15:0]        point_x;
		logic [15:0]        point_y;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               hit;
		logic [31:0]        hit_id;
		logic [14:0]        local_x;
		logic [14:0]        local_y;
		logic signed [15:0] bounds_x;
		logic signed [15:0] bounds_y;
		logic [15:0]        bounds_w;
		logic [15:0]        bounds_h;
	} rsp_t;

	// Field write enables toward the slot table.
	typedef struct packed {
		logic used;
		logic ident;
		logic rect;
		logic shown;
		logic serial;
	} tbl_wen_t;

endpackage

>>> sv/zrht_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrht_slot_table
// Surface slot storage: one read index, one write index with field enables.
// ----------------------------------------------------------------------------
module zrht_slot_table #(
	parameter int N   = 16,
	parameter int IW  = 4,
	parameter int NSW = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IW-1:0]         rd_idx,
	output logic                  rd_used,
	output logic [31:0]           rd_ident,
	output logic signed [15:0]    rd_left,
	output logic signed [15:0]    rd_top,
	output logic signed [15:0]    rd_width,
	output logic signed [15:0]    rd_height,
	output logic                  rd_shown,
	output logic [NSW-1:0]        rd_serial,
	input  logic [IW-1:0]         wr_idx,
	input  zrht_pkg::tbl_wen_t    wen,
	input  logic                  wr_used,
	input  logic [31:0]           wr_ident,
	input  logic signed [15:0]    wr_left,
	input  logic signed [15:0]    wr_top,
	input  logic signed [15:0]    wr_width,
	input  logic signed [15:0]    wr_height,
	input  logic                  wr_shown,
	input  logic [NSW-1:0]        wr_serial
);

	logic [N-1:0]              used_q;
	logic [31:0]               ident_q  [N];
	logic signed [15:0]        left_q   [N];
	logic signed [15:0]        top_q    [N];
	logic signed [15:0]        width_q  [N];
	logic signed [15:0]        height_q [N];
	logic [N-1:0]              shown_q;
	logic [NSW-1:0]            serial_q [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wen.used) begin
			used_q[wr_idx] <= wr_used;
		end
	end

	always_ff @(posedge clk) begin
		if (wen.ident) begin
			ident_q[wr_idx] <= wr_ident;
		end
		if (wen.rect) begin
			left_q[wr_idx]   <= wr_left;
			top_q[wr_idx]    <= wr_top;
			width_q[wr_idx]  <= wr_width;
			height_q[wr_idx] <= wr_height;
		end
		if (wen.shown) begin
			shown_q[wr_idx] <= wr_shown;
		end
		if (wen.serial) begin
			serial_q[wr_idx] <= wr_serial;
		end
	end

	assign rd_used   = used_q[rd_idx];
	assign rd_ident  = ident_q[rd_idx];
	assign rd_left   = left_q[rd_idx];
	assign rd_top    = top_q[rd_idx];
	assign rd_width  = width_q[rd_idx];
	assign rd_height = height_q[rd_idx];
	assign rd_shown  = shown_q[rd_idx];
	assign rd_serial = serial_q[rd_idx];

endmodule

>>> sv/z_ordered_rectangle_hit_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_ordered_rectangle_hit_table
// Table of stacked surface rectangles with update, lookup, bounds and
// point routing, run by a sequencer over a single slot read port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// cmd       in         cmd_valid / cmd_stall   zrht_pkg::cmd_t
// rsp       out        rsp_valid / rsp_stall   zrht_pkg::rsp_t
//
// Update and contains run an id lookup scan, a decide step and a result step.
// Taking a serial adds a take step and a give step; renumbering adds one scan of
// the slots per shown surface of positive size, plus one. Bounds makes one pass over
// the slot read port for the union; route adds one for the hit if the point lies inside.
// cmd_stall is high from the transfer of an item until its result transfers.
// Reset clears the used flags and sets the serial counter to one.
// ----------------------------------------------------------------------------
module z_ordered_rectangle_hit_table #(
	parameter int MAX_SURFACES = 16,
	parameter int SERIAL_BITS  = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  zrht_pkg::cmd_t  cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output zrht_pkg::rsp_t  rsp
);

	localparam int N   = MAX_SURFACES;
	localparam int IW  = (N > 1) ? $clog2(N) : 1;
	localparam int CW  = $clog2(N + 2);
	localparam int NSW = (SERIAL_BITS > CW) ? SERIAL_BITS : CW;
	localparam logic [NSW-1:0] SMAX = NSW'((65'd1 << SERIAL_BITS) - 65'd1);

	zrht_pkg::state_t state_q, state_d;

	zrht_pkg::cmd_t   cmd_q;
	zrht_pkg::rsp_t   res_q;
	logic [IW-1:0]    idx_q;
	logic             found_q, free_q, new_q;
	logic [IW-1:0]    s_q, f_q, tgt_q;
	logic [NSW-1:0]   next_q;
	logic [N-1:0]     done_q;
	logic [CW-1:0]    k_q;
	logic             best_v_q;
	logic [IW-1:0]    best_q;
	logic [NSW-1:0]   best_ser_q;
	logic [31:0]      best_id_q;
	logic             any_q;
	logic signed [17:0] l_q, t_q, r_q, b_q;
	logic signed [18:0] w_q, h_q, px_q, py_q;
	logic             top_v_q;
	logic [NSW-1:0]   top_ser_q;
	logic [31:0]      top_id_q;
	logic signed [15:0] top_l_q, top_t_q;

	logic [IW-1:0]      rd_idx, wr_idx;
	zrht_pkg::tbl_wen_t wen;
	logic [NSW-1:0]     wr_serial;
	logic               e_used, e_shown;
	logic [31:0]        e_ident;
	logic signed [15:0] e_left, e_top, e_width, e_height;
	logic [NSW-1:0]     e_serial;

	logic               last, elig, vis, go_take, e_below_best, top_below_e, in_rect;
	zrht_pkg::status_t  dec_status;
	logic signed [17:0] e_l18, e_t18, e_r18, e_b18;
	logic signed [18:0] w_calc, h_calc;

	zrht_slot_table #(.N(N), .IW(IW), .NSW(NSW)) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx    (rd_idx),
		.rd_used   (e_used),
		.rd_ident  (e_ident),
		.rd_left   (e_left),
		.rd_top    (e_top),
		.rd_width  (e_width),
		.rd_height (e_height),
		.rd_shown  (e_shown),
		.rd_serial (e_serial),
		.wr_idx    (wr_idx),
		.wen       (wen),
		.wr_used   (zrht_pkg::mode_t'(cmd_q.mode) != zrht_pkg::MODE_REMOVE),
		.wr_ident  (cmd_q.surface_id),
		.wr_left   (cmd_q.rect_x),
		.wr_top    (cmd_q.rect_y),
		.wr_width  (cmd_q.rect_w),
		.wr_height (cmd_q.rect_h),
		.wr_shown  (cmd_q.make_visible),
		.wr_serial (wr_serial)
	);

	assign last = (idx_q == IW'(N - 1));
	assign vis  = cmd_q.make_visible;
	assign elig = e_used && e_shown && (e_width > 16'sd0) && (e_height > 16'sd0);

	assign e_l18 = 18'(e_left);
	assign e_t18 = 18'(e_top);
	assign e_r18 = 18'(e_left) + 18'(e_width) - 18'sd1;
	assign e_b18 = 18'(e_top) + 18'(e_height) - 18'sd1;

	assign e_below_best = (e_serial < best_ser_q) ||
		((e_serial == best_ser_q) && (e_ident < best_id_q));
	assign top_below_e = (top_ser_q < e_serial) ||
		((top_ser_q == e_serial) && (top_id_q < e_ident));
	assign in_rect = (px_q >= 19'(e_l18)) && (px_q <= 19'(e_r18)) &&
		(py_q >= 19'(e_t18)) && (py_q <= 19'(e_b18));

	assign w_calc = 19'(r_q) - 19'(l_q) + 19'sd1;
	assign h_calc = 19'(b_q) - 19'(t_q) + 19'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zrht_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		rd_idx     = idx_q;
		wr_idx     = idx_q;
		wen        = '0;
		wr_serial  = '0;
		go_take    = 1'b0;
		dec_status = zrht_pkg::ST_DONE;
		unique case (state_q)
			zrht_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (zrht_pkg::mode_t'(cmd.mode) == zrht_pkg::MODE_BOUNDS ||
					    zrht_pkg::mode_t'(cmd.mode) == zrht_pkg::MODE_ROUTE) begin
						state_d = zrht_pkg::S_UNION;
					end else begin
						state_d = zrht_pkg::S_LOOK;
					end
				end
			end
			zrht_pkg::S_LOOK: begin
				if (last) begin
					state_d = zrht_pkg::S_DECIDE;
				end
			end
			zrht_pkg::S_DECIDE: begin
				rd_idx = s_q;
				wr_idx = s_q;
				unique case (zrht_pkg::mode_t'(cmd_q.mode))
					zrht_pkg::MODE_UPSERT: begin
						if (found_q) begin
							wen.rect  = 1'b1;
							wen.shown = 1'b1;
							go_take   = vis && !e_shown;
						end else if (!free_q) begin
							dec_status = zrht_pkg::ST_FULL;
						end else begin
							wr_idx = f_q;
							if (vis) begin
								go_take = 1'b1;
							end else begin
								wen = '1;
							end
						end
					end
					zrht_pkg::MODE_REMOVE: begin
						if (found_q) wen.used = 1'b1;
						else dec_status = zrht_pkg::ST_ABSENT;
					end
					zrht_pkg::MODE_SET_VIS: begin
						if (!found_q || e_shown == vis) begin
							dec_status = zrht_pkg::ST_ABSENT;
						end else begin
							wen.shown = 1'b1;
							go_take   = vis;
						end
					end
					zrht_pkg::MODE_SET_GEOM: begin
						if (found_q) wen.rect = 1'b1;
						else dec_status = zrht_pkg::ST_ABSENT;
					end
					zrht_pkg::MODE_RAISE: begin
						if (!found_q || !e_shown) dec_status = zrht_pkg::ST_ABSENT;
						else go_take = 1'b1;
					end
					zrht_pkg::MODE_CONTAINS: begin
						if (!found_q) dec_status = zrht_pkg::ST_ABSENT;
					end
					default: begin
					end
				endcase
				state_d = go_take ? zrht_pkg::S_TAKE : zrht_pkg::S_OUT;
			end
			zrht_pkg::S_TAKE: begin
				state_d = (next_q >= SMAX) ? zrht_pkg::S_REN : zrht_pkg::S_GIVE;
			end
			zrht_pkg::S_REN: begin
				if (last) begin
					state_d = zrht_pkg::S_REN_CHK;
				end
			end
			zrht_pkg::S_REN_CHK: begin
				wr_idx    = best_q;
				wr_serial = NSW'(k_q) + NSW'(1);
				if (best_v_q) begin
					wen.serial = 1'b1;
					state_d    = zrht_pkg::S_REN;
				end else begin
					state_d = zrht_pkg::S_GIVE;
				end
			end
			zrht_pkg::S_GIVE: begin
				wr_idx     = tgt_q;
				wr_serial  = next_q & SMAX;
				wen.serial = 1'b1;
				if (new_q) begin
					wen.used  = 1'b1;
					wen.ident = 1'b1;
					wen.rect  = 1'b1;
					wen.shown = 1'b1;
				end
				state_d = zrht_pkg::S_OUT;
			end
			zrht_pkg::S_UNION: begin
				if (last) begin
					state_d = zrht_pkg::S_UEND;
				end
			end
			zrht_pkg::S_UEND: begin
				if (zrht_pkg::mode_t'(cmd_q.mode) == zrht_pkg::MODE_ROUTE && any_q &&
				    px_q < w_calc && py_q < h_calc) begin
					state_d = zrht_pkg::S_ROUTE;
				end else begin
					state_d = zrht_pkg::S_OUT;
				end
			end
			zrht_pkg::S_ROUTE: begin
				if (last) begin
					state_d = zrht_pkg::S_RFIN;
				end
			end
			zrht_pkg::S_RFIN: begin
				state_d = zrht_pkg::S_OUT;
			end
			zrht_pkg::S_OUT: begin
				if (!rsp_stall) begin
					state_d = zrht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = zrht_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= '0;
			res_q      <= '0;
			idx_q      <= '0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			new_q      <= 1'b0;
			s_q        <= '0;
			f_q        <= '0;
			tgt_q      <= '0;
			next_q     <= NSW'(1);
			done_q     <= '0;
			k_q        <= '0;
			best_v_q   <= 1'b0;
			best_q     <= '0;
			best_ser_q <= '0;
			best_id_q  <= '0;
			any_q      <= 1'b0;
			l_q        <= '0;
			t_q        <= '0;
			r_q        <= '0;
			b_q        <= '0;
			w_q        <= '0;
			h_q        <= '0;
			px_q       <= '0;
			py_q       <= '0;
			top_v_q    <= 1'b0;
			top_ser_q  <= '0;
			top_id_q   <= '0;
			top_l_q    <= '0;
			top_t_q    <= '0;
		end else begin
			unique case (state_q)
				zrht_pkg::S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						res_q   <= '0;
						idx_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						any_q   <= 1'b0;
						top_v_q <= 1'b0;
						px_q    <= 19'({3'b000, cmd.point_x});
						py_q    <= 19'({3'b000, cmd.point_y});
					end
				end
				zrht_pkg::S_LOOK: begin
					if (e_used && e_ident == cmd_q.surface_id && !found_q) begin
						found_q <= 1'b1;
						s_q     <= idx_q;
					end
					if (!e_used && !free_q) begin
						free_q <= 1'b1;
						f_q    <= idx_q;
					end
					idx_q <= idx_q + IW'(1);
				end
				zrht_pkg::S_DECIDE: begin
					res_q.status <= dec_status;
					res_q.hit    <= (zrht_pkg::mode_t'(cmd_q.mode) == zrht_pkg::MODE_CONTAINS)
						&& found_q;
					tgt_q        <= found_q ? s_q : f_q;
					new_q        <= !found_q;
				end
				zrht_pkg::S_TAKE: begin
					idx_q    <= '0;
					k_q      <= '0;
					done_q   <= '0;
					best_v_q <= 1'b0;
				end
				zrht_pkg::S_REN: begin
					if (elig && !done_q[idx_q] && (!best_v_q || e_below_best)) begin
						best_v_q   <= 1'b1;
						best_q     <= idx_q;
						best_ser_q <= e_serial;
						best_id_q  <= e_ident;
					end
					idx_q <= idx_q + IW'(1);
				end
				zrht_pkg::S_REN_CHK: begin
					idx_q <= '0;
					if (best_v_q) begin
						done_q[best_q] <= 1'b1;
						k_q            <= k_q + CW'(1);
						best_v_q       <= 1'b0;
					end else begin
						next_q <= NSW'(k_q) + NSW'(1);
					end
				end
				zrht_pkg::S_GIVE: begin
					next_q <= next_q + NSW'(1);
				end
				zrht_pkg::S_UNION: begin
					if (elig) begin
						any_q <= 1'b1;
						if (!any_q || e_l18 < l_q) l_q <= e_l18;
						if (!any_q || e_t18 < t_q) t_q <= e_t18;
						if (!any_q || e_r18 > r_q) r_q <= e_r18;
						if (!any_q || e_b18 > b_q) b_q <= e_b18;
					end
					idx_q <= idx_q + IW'(1);
				end
				zrht_pkg::S_UEND: begin
					idx_q <= '0;
					w_q   <= w_calc;
					h_q   <= h_calc;
					if (any_q) begin
						res_q.bounds_x <= l_q[15:0];
						res_q.bounds_y <= t_q[15:0];
						res_q.bounds_w <= (w_calc > 19'sd65535) ? 16'hFFFF : w_calc[15:0];
						res_q.bounds_h <= (h_calc > 19'sd65535) ? 16'hFFFF : h_calc[15:0];
					end
					if (zrht_pkg::mode_t'(cmd_q.mode) == zrht_pkg::MODE_ROUTE) begin
						res_q.status <= zrht_pkg::ST_MISS;
						px_q         <= px_q + 19'(l_q);
						py_q         <= py_q + 19'(t_q);
					end
				end
				zrht_pkg::S_ROUTE: begin
					if (elig && in_rect && (!top_v_q || top_below_e)) begin
						top_v_q   <= 1'b1;
						top_ser_q <= e_serial;
						top_id_q  <= e_ident;
						top_l_q   <= e_left;
						top_t_q   <= e_top;
					end
					idx_q <= idx_q + IW'(1);
				end
				zrht_pkg::S_RFIN: begin
					if (top_v_q) begin
						res_q.status  <= zrht_pkg::ST_DONE;
						res_q.hit     <= 1'b1;
						res_q.hit_id  <= top_id_q;
						res_q.local_x <= 15'(px_q - 19'(top_l_q));
						res_q.local_y <= 15'(py_q - 19'(top_t_q));
					end
				end
				zrht_pkg::S_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != zrht_pkg::S_IDLE);
	assign rsp_valid = (state_q == zrht_pkg::S_OUT);
	assign rsp       = res_q;

	// A point inside the union always lies below the union size.
	ap_route_in_union: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zrht_pkg::S_ROUTE) |->
			(px_q >= 19'(l_q) && px_q < 19'(l_q) + w_q &&
			 py_q >= 19'(t_q) && py_q < 19'(t_q) + h_q))
		else $error("route point left the union");

	ap_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> cmd_stall)
		else $error("new item could transfer while a result waits");

	ap_serial_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_q != '0)
		else $error("serial counter reached zero");

	ap_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.hit) |-> (rsp.status == zrht_pkg::ST_DONE))
		else $error("hit reported with a failing status");

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (!rsp_valid && cmd_stall))
		else $error("sequencer did not start after a transfer");

endmodule

>>> test/z_ordered_rectangle_hit_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_ordered_rectangle_hit_table_test
// Drives surface table commands with random idling and receiver back-pressure,
// predicts every response from a private copy of the table and checks it.
// ----------------------------------------------------------------------------

class surface_table_board;
	localparam int NSLOT = 16;
	bit          used [NSLOT];
	bit [31:0]   ident [NSLOT];
	int          left [NSLOT], top [NSLOT], wid [NSLOT], hgt [NSLOT];
	bit          shown [NSLOT];
	bit [63:0]   serial [NSLOT];
	bit [63:0]   next_serial;
	zrht_pkg::rsp_t pending [$];
	int          errors;
	int          checked;

	function new();
		foreach (used[i]) used[i] = 0;
		next_serial = 64'd1;
		errors = 0;
		checked = 0;
	endfunction

	function bit visible_rect(int i);
		return used[i] && shown[i] && wid[i] > 0 && hgt[i] > 0;
	endfunction

	function bit lies_under(int a, int b);
		if (serial[a] != serial[b]) return serial[a] < serial[b];
		return ident[a] < ident[b];
	endfunction

	function int find_slot(bit [31:0] id);
		for (int i = 0; i < NSLOT; i++)
			if (used[i] && ident[i] == id) return i;
		return -1;
	endfunction

	function bit [63:0] next_stack_serial();
		bit [63:0] rank [NSLOT];
		bit [63:0] k;
		bit [63:0] v;
		if (next_serial >= 64'hFFFF_FFFF_FFFF_FFFF) begin
			k = 0;
			for (int i = 0; i < NSLOT; i++) begin
				rank[i] = 0;
				if (!visible_rect(i)) continue;
				k++;
				for (int j = 0; j < NSLOT; j++)
					if (j != i && visible_rect(j) && lies_under(j, i)) rank[i]++;
			end
			for (int i = 0; i < NSLOT; i++)
				if (visible_rect(i)) serial[i] = rank[i] + 1;
			next_serial = k + 1;
		end
		v = next_serial;
		next_serial++;
		return v;
	endfunction

	function void put_rect(int i, zrht_pkg::cmd_t c);
		left[i] = c.rect_x;
		top[i] = c.rect_y;
		wid[i] = c.rect_w;
		hgt[i] = c.rect_h;
	endfunction

	// Applies one accepted command and queues the response it must produce.
	function void note_command(zrht_pkg::cmd_t c);
		zrht_pkg::rsp_t r;
		int s, f, l, t, rr, b, w, h, px, py, hi;
		bit any, became;
		r = '0;
		s = find_slot(c.surface_id);
		case (zrht_pkg::mode_t'(c.mode))
			zrht_pkg::MODE_UPSERT: begin
				if (s >= 0) begin
					became = c.make_visible && !shown[s];
					put_rect(s, c);
					shown[s] = c.make_visible;
					if (became) serial[s] = next_stack_serial();
				end else begin
					f = -1;
					for (int i = 0; i < NSLOT; i++)
						if (!used[i]) begin
							f = i;
							break;
						end
					if (f < 0) r.status = zrht_pkg::ST_FULL;
					else begin
						serial[f] = c.make_visible ? next_stack_serial() : 64'd0;
						ident[f] = c.surface_id;
						put_rect(f, c);
						shown[f] = c.make_visible;
						used[f] = 1;
					end
				end
			end
			zrht_pkg::MODE_REMOVE:
				if (s < 0) r.status = zrht_pkg::ST_ABSENT; else used[s] = 0;
			zrht_pkg::MODE_SET_VIS: begin
				if (s < 0 || shown[s] == c.make_visible) r.status = zrht_pkg::ST_ABSENT;
				else begin
					shown[s] = c.make_visible;
					if (c.make_visible) serial[s] = next_stack_serial();
				end
			end
			zrht_pkg::MODE_SET_GEOM:
				if (s < 0) r.status = zrht_pkg::ST_ABSENT; else put_rect(s, c);
			zrht_pkg::MODE_RAISE: begin
				if (s < 0 || !shown[s]) r.status = zrht_pkg::ST_ABSENT;
				else serial[s] = next_stack_serial();
			end
			zrht_pkg::MODE_CONTAINS:
				if (s < 0) r.status = zrht_pkg::ST_ABSENT; else r.hit = 1;
			default: begin
				any = 0;
				l = 0; t = 0; rr = 0; b = 0; w = 0; h = 0;
				for (int i = 0; i < NSLOT; i++) begin
					if (!visible_rect(i)) continue;
					if (!any || left[i] < l) l = left[i];
					if (!any || top[i] < t) t = top[i];
					if (!any || left[i] + wid[i] - 1 > rr) rr = left[i] + wid[i] - 1;
					if (!any || top[i] + hgt[i] - 1 > b) b = top[i] + hgt[i] - 1;
					any = 1;
				end
				if (any) begin
					w = rr - l + 1;
					h = b - t + 1;
					r.bounds_x = l[15:0];
					r.bounds_y = t[15:0];
					r.bounds_w = w > 65535 ? 16'hFFFF : w[15:0];
					r.bounds_h = h > 65535 ? 16'hFFFF : h[15:0];
				end
				if (c.mode == zrht_pkg::MODE_ROUTE) begin
					r.status = zrht_pkg::ST_MISS;
					px = c.point_x;
					py = c.point_y;
					if (any && px < w && py < h) begin
						px += l;
						py += t;
						hi = -1;
						for (int i = 0; i < NSLOT; i++) begin
							if (!visible_rect(i)) continue;
							if (px < left[i] || px > left[i] + wid[i] - 1) continue;
							if (py < top[i] || py > top[i] + hgt[i] - 1) continue;
							if (hi < 0 || lies_under(hi, i)) hi = i;
						end
						if (hi >= 0) begin
							r.status = zrht_pkg::ST_DONE;
							r.hit = 1;
							r.hit_id = ident[hi];
							r.local_x = 15'(px - left[hi]);
							r.local_y = 15'(py - top[hi]);
						end
					end
				end
			end
		endcase
		pending.insert(pending.size(), r);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task check_response(zrht_pkg::rsp_t got);
		zrht_pkg::rsp_t want;
		checked++;
		if (pending.size() == 0) begin
			report("unexpected response", 64'(got.status), 64'd0);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) report("status", got.status, want.status);
		if (got.hit !== want.hit) report("hit", got.hit, want.hit);
		if (got.hit_id !== want.hit_id) report("hit_id", got.hit_id, want.hit_id);
		if (got.local_x !== want.local_x) report("local_x", got.local_x, want.local_x);
		if (got.local_y !== want.local_y) report("local_y", got.local_y, want.local_y);
		if (got.bounds_x !== want.bounds_x) report("bounds_x", got.bounds_x, want.bounds_x);
		if (got.bounds_y !== want.bounds_y) report("bounds_y", got.bounds_y, want.bounds_y);
		if (got.bounds_w !== want.bounds_w) report("bounds_w", got.bounds_w, want.bounds_w);
		if (got.bounds_h !== want.bounds_h) report("bounds_h", got.bounds_h, want.bounds_h);
	endtask
endclass

module z_ordered_rectangle_hit_table_test;
	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	zrht_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	zrht_pkg::rsp_t rsp;

	surface_table_board board;
	zrht_pkg::cmd_t directed_q [$];
	bit calm;          // no idling on either side
	bit hold_off_req;  // receiver holds off for a long stretch
	bit hold_off_busy;
	int sent;

	z_ordered_rectangle_hit_table DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	// Ids come from a small pool so that operations find their surfaces.
	function bit [31:0] pick_id();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0;
			2: return $urandom();
			default: return 32'h100 + $urandom_range(0, 19);
		endcase
	endfunction

	function logic [15:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 16'($urandom());
			1: return 16'h0;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom_range(1, 200));
		endcase
	endfunction

	function zrht_pkg::cmd_t random_command();
		zrht_pkg::cmd_t c;
		c.mode = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0) c.mode = zrht_pkg::MODE_ROUTE;
		c.surface_id = pick_id();
		c.rect_x = $urandom_range(0, 4) == 0 ? 16'($urandom())
			: 16'($urandom_range(0, 400) - 200);
		c.rect_y = $urandom_range(0, 4) == 0 ? 16'($urandom())
			: 16'($urandom_range(0, 400) - 200);
		c.rect_w = pick_size();
		c.rect_h = pick_size();
		c.make_visible = $urandom_range(0, 3) != 0;
		c.point_x = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 300));
		c.point_y = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 300));
		return c;
	endfunction

	function zrht_pkg::cmd_t make_cmd(zrht_pkg::mode_t m, bit [31:0] id, int x, int y,
			int w, int h, bit vis, int px, int py);
		zrht_pkg::cmd_t c;
		c.mode = m;
		c.surface_id = id;
		c.rect_x = x[15:0];
		c.rect_y = y[15:0];
		c.rect_w = w[15:0];
		c.rect_h = h[15:0];
		c.make_visible = vis;
		c.point_x = px[15:0];
		c.point_y = py[15:0];
		return c;
	endfunction

	function void add_directed(zrht_pkg::cmd_t c);
		directed_q.insert(directed_q.size(), c);
	endfunction

	// Valid stays high from one item to the next when there is no idle gap.
	task send_command(zrht_pkg::cmd_t c);
		while (!calm && $urandom_range(0, 99) < 38) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		board.note_command(c);
		sent++;
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int n;
		rsp_stall = 1'b1;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) board.check_response(rsp);
			if (hold_off_req && !hold_off_busy) begin
				hold_off_busy = 1;
				rsp_stall <= 1'b1;
				for (n = 0; n < 400; n++) @(posedge clk);
				hold_off_req = 0;
				hold_off_busy = 0;
			end
			rsp_stall <= !calm && $urandom_range(0, 99) < 38;
		end
	end

	initial begin
		int k;
		board = new();
		sent = 0;
		calm = 0;
		hold_off_req = 0;
		hold_off_busy = 0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-table queries, one of each operation, extremes and overlap.
		add_directed(make_cmd(zrht_pkg::MODE_BOUNDS, 0, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_UPSERT, 1, -32768, -32768, 32767, 32767,
			1, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_UPSERT, 2, 32767, 32767, 32767, 32767,
			1, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_BOUNDS, 0, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 65535, 65535));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 32767, 32767));
		add_directed(make_cmd(zrht_pkg::MODE_UPSERT, 32'hFFFF_FFFF, 10, 10, 0, 5,
			1, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_UPSERT, 3, 0, 0, -32768, 5, 1, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_SET_GEOM, 1, 0, 0, 50, 50, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_SET_GEOM, 2, 10, 10, 50, 50, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 20, 20));
		add_directed(make_cmd(zrht_pkg::MODE_RAISE, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 20, 20));
		add_directed(make_cmd(zrht_pkg::MODE_SET_VIS, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_SET_VIS, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_RAISE, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_CONTAINS, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_CONTAINS, 77, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0));
		add_directed(make_cmd(zrht_pkg::MODE_ROUTE, 0, 0, 0, 0, 0, 0, 60, 0));
		foreach (directed_q[i]) send_command(directed_q[i]);

		// Fill the table until an insert is refused, then remove the surfaces it added.
		for (k = 0; k < 18; k++)
			send_command(make_cmd(zrht_pkg::MODE_UPSERT, 32'h900 + k, k, k, 8, 8,
				k[0], 3, 3));
		for (k = 0; k < 18; k++)
			send_command(make_cmd(zrht_pkg::MODE_REMOVE, 32'h900 + k, 0, 0, 0, 0,
				0, 0, 0));

		for (k = 0; k < 1600; k++) begin
			calm = k >= 500 && k < 750;
			if (k == 900) hold_off_req = 1;
			send_command(random_command());
		end
		cmd_valid <= 1'b0;
		calm = 0;

		k = 0;
		while (board.pending.size() != 0 && k < 200000) begin
			@(posedge clk);
			k++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d commands over all eight modes, %0d responses checked,",
			sent, board.checked);
		$display("including a full table, extreme rectangles and a long receiver hold-off.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
